/* sv/first_fit_allocator_with_wait_queue_defines.svh */
// Assertion macros for the first-fit allocator checker.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef FIRST_FIT_ALLOCATOR_WITH_WAIT_QUEUE_DEFINES_SVH
`define FIRST_FIT_ALLOCATOR_WITH_WAIT_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define FFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/ffa_pkg.sv */
// Shared types and constants of the first-fit allocator.
// No dependencies.
package ffa_pkg;

  localparam logic       OP_REQ     = 1'b0;
  localparam logic       OP_FIN     = 1'b1;
  localparam logic [31:0] NONE_PENDING = 32'hFFFF_FFFF;
  localparam logic [31:0] LAST_TIME    = 32'hFFFF_FFFE;
  localparam logic [30:0] WAIT_MAX     = 31'h7FFF_FFFF;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH,
    S_REL_START, S_REL_ISSUE, S_REL_EVAL,
    S_QCHECK, S_QLOAD,
    S_P_START, S_P_HEAD, S_P_ISSUE, S_P_EVAL, S_P_COMMIT, S_P_DONE,
    S_FIN_ISSUE, S_FIN_EVAL,
    S_RESULT
  } ffa_state_t;

endpackage

/* sv/ffa_block_table.sv */
// Block table storage: position, length, release time and list link per slot.
// Depends on nothing; one read port with registered data, two write ports.
module ffa_block_table #(
  parameter int MAX_BLOCKS = 64,
  parameter int SW = $clog2(MAX_BLOCKS),
  parameter int LW = $clog2(MAX_BLOCKS + 1)
) (
  input  logic          clk,
  input  logic [SW-1:0] rd_addr,
  output logic [30:0]   rd_pos,
  output logic [30:0]   rd_len,
  output logic [31:0]   rd_rel,
  output logic [LW-1:0] rd_link,
  input  logic          ent_we,
  input  logic [SW-1:0] ent_addr,
  input  logic [30:0]   ent_pos,
  input  logic [30:0]   ent_len,
  input  logic [31:0]   ent_rel,
  input  logic          lnk_we,
  input  logic [SW-1:0] lnk_addr,
  input  logic [LW-1:0] lnk_data
);

  logic [30:0]   pos_mem  [MAX_BLOCKS];
  logic [30:0]   len_mem  [MAX_BLOCKS];
  logic [31:0]   rel_mem  [MAX_BLOCKS];
  logic [LW-1:0] link_mem [MAX_BLOCKS];

  // Write entry fields together, link on its own port
  always_ff @(posedge clk) begin
    if (ent_we) begin
      pos_mem[ent_addr] <= ent_pos;
      len_mem[ent_addr] <= ent_len;
      rel_mem[ent_addr] <= ent_rel;
    end
    if (lnk_we) begin
      link_mem[lnk_addr] <= lnk_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_pos  <= pos_mem[rd_addr];
    rd_len  <= len_mem[rd_addr];
    rd_rel  <= rel_mem[rd_addr];
    rd_link <= link_mem[rd_addr];
  end

endmodule

/* sv/first_fit_allocator_with_wait_queue.sv */
// A request on an empty list passes DISPATCH, P_START, P_COMMIT and P_DONE before out_tvalid;
// a finish with nothing held or queued passes DISPATCH and FIN_ISSUE. Each release step walks
// the list with an issue and an evaluate state per block held, and each first-fit placement
// walks it again the same way per block passed, so a long chain of releases slows a request.
// Throughput: one transaction at a time; in_tready returns in the cycle after the result is taken.
// Reset (rst_n low, synchronous) empties list and queue, frees all slots, sets memory_size 1024.
module first_fit_allocator_with_wait_queue #(
  parameter int MAX_BLOCKS  = 64,
  parameter int MAX_WAITING = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // arrival_time[30:0], request_size[61:31], hold_time[92:62], zero pad [95:93]
  input  logic [95:0] in_tdata,
  // operation[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // had_to_wait[0], wait_count[31:1], end_time[63:32], queue_overflow[64], pad [71:65]
  output logic [71:0] out_tdata,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata
);

  localparam int SW = $clog2(MAX_BLOCKS);
  localparam int LW = $clog2(MAX_BLOCKS + 1);
  localparam int QW = $clog2(MAX_WAITING);
  localparam int FW = $clog2(MAX_WAITING + 1);
  localparam int GUARD_LIM = 2 * (MAX_BLOCKS + MAX_WAITING) + 4;
  localparam int GW = $clog2(GUARD_LIM + 1);
  localparam logic [LW-1:0] NIL = LW'(MAX_BLOCKS);

  ffa_pkg::ffa_state_t state_r, state_nxt;

  logic          op_r, op_nxt;
  logic [30:0]   arr_r, arr_nxt;
  logic [30:0]   rsize_r, rsize_nxt;
  logic [30:0]   rhold_r, rhold_nxt;
  logic [30:0]   memsize_r;
  logic [LW-1:0] head_r, head_nxt;
  logic [MAX_BLOCKS-1:0] free_r, free_nxt;
  logic [QW-1:0] rdp_r, rdp_nxt;
  logic [QW-1:0] wrp_r, wrp_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [31:0]   nrel_r, nrel_nxt;
  logic [30:0]   wtot_r, wtot_nxt;
  logic [GW-1:0] guard_r, guard_nxt;
  logic [31:0]   t_r, t_nxt;
  logic [31:0]   earliest_r, earliest_nxt;
  logic [LW-1:0] prev_r, prev_nxt;
  logic [LW-1:0] cur_r, cur_nxt;
  logic [30:0]   psize_r, psize_nxt;
  logic [30:0]   phold_r, phold_nxt;
  logic [31:0]   pstart_r, pstart_nxt;
  logic          pq_r, pq_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [31:0]   pend_r, pend_nxt;
  logic [LW-1:0] plink_r, plink_nxt;
  logic [30:0]   ppos_r, ppos_nxt;
  logic          pok_r, pok_nxt;
  logic [31:0]   prel_r, prel_nxt;
  logic          pafter_r, pafter_nxt;
  logic          waited_r, waited_nxt;
  logic          ovf_r, ovf_nxt;
  logic [31:0]   endt_r, endt_nxt;

  // Table ports
  logic [SW-1:0] tb_rd_addr;
  logic [30:0]   tb_pos, tb_len;
  logic [31:0]   tb_rel;
  logic [LW-1:0] tb_link;
  logic          ent_we, lnk_we;
  logic [SW-1:0] lnk_addr;
  logic [LW-1:0] lnk_data;

  // Wait queue
  logic [30:0] qsize_mem [MAX_WAITING];
  logic [30:0] qhold_mem [MAX_WAITING];
  logic [30:0] qsize_q, qhold_q;
  logic        q_we;

  logic in_acc;
  logic guard_ok, is_fin, go_rel;
  logic slot_any;
  logic [SW-1:0] slot_idx;
  logic [31:0] blk_end;
  logic [32:0] need_end, rel_sum;
  logic [31:0] new_rel;
  logic fit_front, fit_mem, fit_nxt;

  assign in_acc   = in_tvalid && in_tready;
  assign guard_ok = guard_r < GW'(GUARD_LIM);
  assign is_fin   = (op_r == ffa_pkg::OP_FIN);
  assign go_rel   = guard_ok && (is_fin ? (fill_r != '0) : ({1'b0, arr_r} >= nrel_r));

  // Find lowest free slot
  always_comb begin
    slot_any = 1'b0;
    slot_idx = '0;
    for (int s = MAX_BLOCKS - 1; s >= 0; s--) begin
      if (free_r[s]) begin
        slot_any = 1'b1;
        slot_idx = SW'(s);
      end
    end
  end

  // Shared add and compare unit
  assign blk_end   = {1'b0, tb_pos} + {1'b0, tb_len};
  assign need_end  = {1'b0, pend_r} + {2'b0, psize_r};
  assign fit_front = tb_pos >= psize_r;
  assign fit_mem   = {2'b0, memsize_r} >= need_end;
  assign fit_nxt   = {2'b0, tb_pos} >= need_end;
  assign rel_sum   = {1'b0, pstart_r} + {2'b0, phold_r};
  assign new_rel   = (rel_sum > {1'b0, ffa_pkg::LAST_TIME}) ? ffa_pkg::LAST_TIME
                                                            : rel_sum[31:0];

  ffa_block_table #(.MAX_BLOCKS(MAX_BLOCKS), .SW(SW), .LW(LW)) u_table (
    .clk      (clk),
    .rd_addr  (tb_rd_addr),
    .rd_pos   (tb_pos),
    .rd_len   (tb_len),
    .rd_rel   (tb_rel),
    .rd_link  (tb_link),
    .ent_we   (ent_we),
    .ent_addr (slot_r),
    .ent_pos  (ppos_r),
    .ent_len  (psize_r),
    .ent_rel  (new_rel),
    .lnk_we   (lnk_we),
    .lnk_addr (lnk_addr),
    .lnk_data (lnk_data)
  );

  // Wait queue storage
  always_ff @(posedge clk) begin
    if (q_we) begin
      qsize_mem[wrp_r] <= rsize_r;
      qhold_mem[wrp_r] <= rhold_r;
    end
    qsize_q <= qsize_mem[rdp_r];
    qhold_q <= qhold_mem[rdp_r];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffa_pkg::S_IDLE:      if (in_acc) state_nxt = ffa_pkg::S_DISPATCH;
      ffa_pkg::S_DISPATCH: begin
        if (go_rel)      state_nxt = ffa_pkg::S_REL_START;
        else if (is_fin) state_nxt = ffa_pkg::S_FIN_ISSUE;
        else             state_nxt = ffa_pkg::S_P_START;
      end
      ffa_pkg::S_REL_START: state_nxt = ffa_pkg::S_REL_ISSUE;
      ffa_pkg::S_REL_ISSUE: state_nxt = (cur_r == NIL) ? ffa_pkg::S_QCHECK
                                                       : ffa_pkg::S_REL_EVAL;
      ffa_pkg::S_REL_EVAL:  state_nxt = ffa_pkg::S_REL_ISSUE;
      ffa_pkg::S_QCHECK:    state_nxt = (fill_r != '0) ? ffa_pkg::S_QLOAD
                                                       : ffa_pkg::S_DISPATCH;
      ffa_pkg::S_QLOAD:     state_nxt = ffa_pkg::S_P_START;
      ffa_pkg::S_P_START: begin
        if (!slot_any)        state_nxt = ffa_pkg::S_P_DONE;
        else if (head_r == NIL) state_nxt = ffa_pkg::S_P_COMMIT;
        else                  state_nxt = ffa_pkg::S_P_HEAD;
      end
      ffa_pkg::S_P_HEAD:    state_nxt = fit_front ? ffa_pkg::S_P_COMMIT : ffa_pkg::S_P_ISSUE;
      ffa_pkg::S_P_ISSUE: begin
        if (plink_r != NIL) state_nxt = ffa_pkg::S_P_EVAL;
        else if (fit_mem)   state_nxt = ffa_pkg::S_P_COMMIT;
        else                state_nxt = ffa_pkg::S_P_DONE;
      end
      ffa_pkg::S_P_EVAL:    state_nxt = fit_nxt ? ffa_pkg::S_P_COMMIT : ffa_pkg::S_P_ISSUE;
      ffa_pkg::S_P_COMMIT:  state_nxt = ffa_pkg::S_P_DONE;
      ffa_pkg::S_P_DONE: begin
        if (!pq_r)      state_nxt = ffa_pkg::S_RESULT;
        else if (pok_r) state_nxt = ffa_pkg::S_QCHECK;
        else            state_nxt = ffa_pkg::S_DISPATCH;
      end
      ffa_pkg::S_FIN_ISSUE: state_nxt = (cur_r == NIL) ? ffa_pkg::S_RESULT
                                                       : ffa_pkg::S_FIN_EVAL;
      ffa_pkg::S_FIN_EVAL:  state_nxt = ffa_pkg::S_FIN_ISSUE;
      ffa_pkg::S_RESULT:    if (out_tready) state_nxt = ffa_pkg::S_IDLE;
      default:              state_nxt = ffa_pkg::S_IDLE;
    endcase
  end

  // Datapath next values
  always_comb begin
    op_nxt = op_r; arr_nxt = arr_r; rsize_nxt = rsize_r; rhold_nxt = rhold_r;
    head_nxt = head_r; free_nxt = free_r; rdp_nxt = rdp_r; wrp_nxt = wrp_r;
    fill_nxt = fill_r; nrel_nxt = nrel_r; wtot_nxt = wtot_r; guard_nxt = guard_r;
    t_nxt = t_r; earliest_nxt = earliest_r; prev_nxt = prev_r; cur_nxt = cur_r;
    psize_nxt = psize_r; phold_nxt = phold_r; pstart_nxt = pstart_r; pq_nxt = pq_r;
    slot_nxt = slot_r; pend_nxt = pend_r; plink_nxt = plink_r; ppos_nxt = ppos_r;
    pok_nxt = pok_r; prel_nxt = prel_r; pafter_nxt = pafter_r;
    waited_nxt = waited_r; ovf_nxt = ovf_r; endt_nxt = endt_r;
    case (state_r)
      ffa_pkg::S_IDLE: begin
        if (in_acc) begin
          op_nxt     = in_tuser;
          arr_nxt    = in_tdata[30:0];
          rsize_nxt  = in_tdata[61:31];
          rhold_nxt  = in_tdata[92:62];
          guard_nxt  = '0;
          endt_nxt   = '0;
          waited_nxt = 1'b0;
          ovf_nxt    = 1'b0;
        end
      end
      ffa_pkg::S_DISPATCH: begin
        if (!go_rel && is_fin) begin
          cur_nxt = head_r;
        end else if (!go_rel) begin
          psize_nxt  = rsize_r;
          phold_nxt  = rhold_r;
          pstart_nxt = {1'b0, arr_r};
          pq_nxt     = 1'b0;
        end
      end
      ffa_pkg::S_REL_START: begin
        t_nxt        = nrel_r;
        earliest_nxt = ffa_pkg::NONE_PENDING;
        prev_nxt     = NIL;
        cur_nxt      = head_r;
        guard_nxt    = guard_r + GW'(1);
      end
      ffa_pkg::S_REL_EVAL: begin
        // Unlink blocks due now, track earliest of the rest
        if (tb_rel == t_r) begin
          if (prev_r == NIL) head_nxt = tb_link;
          free_nxt[cur_r[SW-1:0]] = 1'b1;
        end else begin
          if (tb_rel < earliest_r) earliest_nxt = tb_rel;
          prev_nxt = cur_r;
        end
        cur_nxt = tb_link;
      end
      ffa_pkg::S_QCHECK: begin
        if (fill_r == '0) nrel_nxt = earliest_r;
      end
      ffa_pkg::S_QLOAD: begin
        psize_nxt  = qsize_q;
        phold_nxt  = qhold_q;
        pstart_nxt = t_r;
        pq_nxt     = 1'b1;
      end
      ffa_pkg::S_P_START: begin
        slot_nxt   = slot_idx;
        pafter_nxt = 1'b0;
        ppos_nxt   = '0;
        if (!slot_any) pok_nxt = 1'b0;
        else if (head_r == NIL) head_nxt = LW'(slot_idx);
      end
      ffa_pkg::S_P_HEAD: begin
        if (fit_front) begin
          head_nxt = LW'(slot_r);
        end else begin
          cur_nxt   = head_r;
          pend_nxt  = blk_end;
          plink_nxt = tb_link;
        end
      end
      ffa_pkg::S_P_ISSUE: begin
        if (plink_r == NIL) begin
          pok_nxt    = 1'b0;
          ppos_nxt   = pend_r[30:0];
          pafter_nxt = 1'b1;
        end
      end
      ffa_pkg::S_P_EVAL: begin
        if (fit_nxt) begin
          ppos_nxt   = pend_r[30:0];
          pafter_nxt = 1'b1;
        end else begin
          cur_nxt   = plink_r;
          pend_nxt  = blk_end;
          plink_nxt = tb_link;
        end
      end
      ffa_pkg::S_P_COMMIT: begin
        free_nxt[slot_r] = 1'b0;
        prel_nxt = new_rel;
        pok_nxt  = 1'b1;
      end
      ffa_pkg::S_P_DONE: begin
        if (pq_r) begin
          if (pok_r) begin
            if (prel_r < earliest_r) earliest_nxt = prel_r;
            rdp_nxt  = (rdp_r == QW'(MAX_WAITING - 1)) ? '0 : rdp_r + QW'(1);
            fill_nxt = fill_r - FW'(1);
          end else begin
            nrel_nxt = earliest_r;
          end
        end else if (pok_r) begin
          if (prel_r < nrel_r) nrel_nxt = prel_r;
        end else begin
          // Request waits: count it, queue it or drop it
          waited_nxt = 1'b1;
          if (wtot_r != ffa_pkg::WAIT_MAX) wtot_nxt = wtot_r + 31'd1;
          if (fill_r < FW'(MAX_WAITING)) begin
            wrp_nxt  = (wrp_r == QW'(MAX_WAITING - 1)) ? '0 : wrp_r + QW'(1);
            fill_nxt = fill_r + FW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ffa_pkg::S_FIN_EVAL: begin
        if (tb_rel > endt_r) endt_nxt = tb_rel;
        cur_nxt = tb_link;
      end
      default: ;
    endcase
  end

  // Outputs and storage controls
  always_comb begin
    in_tready  = (state_r == ffa_pkg::S_IDLE);
    out_tvalid = (state_r == ffa_pkg::S_RESULT);
    tb_rd_addr = cur_r[SW-1:0];
    ent_we     = 1'b0;
    lnk_we     = 1'b0;
    lnk_addr   = slot_r;
    lnk_data   = NIL;
    q_we       = 1'b0;
    case (state_r)
      ffa_pkg::S_P_START: begin
        tb_rd_addr = head_r[SW-1:0];
        lnk_addr   = slot_idx;
        lnk_data   = head_r;
        lnk_we     = slot_any && (head_r == NIL);
      end
      ffa_pkg::S_REL_EVAL: begin
        lnk_addr = prev_r[SW-1:0];
        lnk_data = tb_link;
        lnk_we   = (tb_rel == t_r) && (prev_r != NIL);
      end
      ffa_pkg::S_P_HEAD: begin
        lnk_data = head_r;
        lnk_we   = fit_front;
      end
      ffa_pkg::S_P_ISSUE: begin
        tb_rd_addr = plink_r[SW-1:0];
        lnk_data   = NIL;
        lnk_we     = (plink_r == NIL) && fit_mem;
      end
      ffa_pkg::S_P_EVAL: begin
        lnk_data = plink_r;
        lnk_we   = fit_nxt;
      end
      ffa_pkg::S_P_COMMIT: begin
        ent_we   = 1'b1;
        lnk_addr = cur_r[SW-1:0];
        lnk_data = LW'(slot_r);
        lnk_we   = pafter_r;
      end
      ffa_pkg::S_P_DONE: begin
        q_we = !pq_r && !pok_r && (fill_r < FW'(MAX_WAITING));
      end
      default: ;
    endcase
  end

  assign out_tdata = {7'd0, ovf_r, endt_r, wtot_r, waited_r};

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ffa_pkg::S_IDLE;
      memsize_r <= 31'd1024;
      head_r    <= NIL;
      free_r    <= '1;
      rdp_r     <= '0;
      wrp_r     <= '0;
      fill_r    <= '0;
      nrel_r    <= ffa_pkg::NONE_PENDING;
      wtot_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) memsize_r <= cfg_wdata;
      head_r  <= head_nxt;
      free_r  <= free_nxt;
      rdp_r   <= rdp_nxt;
      wrp_r   <= wrp_nxt;
      fill_r  <= fill_nxt;
      nrel_r  <= nrel_nxt;
      wtot_r  <= wtot_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    op_r <= op_nxt; arr_r <= arr_nxt; rsize_r <= rsize_nxt; rhold_r <= rhold_nxt;
    guard_r <= guard_nxt; t_r <= t_nxt; earliest_r <= earliest_nxt;
    prev_r <= prev_nxt; cur_r <= cur_nxt; psize_r <= psize_nxt; phold_r <= phold_nxt;
    pstart_r <= pstart_nxt; pq_r <= pq_nxt; slot_r <= slot_nxt; pend_r <= pend_nxt;
    plink_r <= plink_nxt; ppos_r <= ppos_nxt; pok_r <= pok_nxt; prel_r <= prel_nxt;
    pafter_r <= pafter_nxt; waited_r <= waited_nxt; ovf_r <= ovf_nxt; endt_r <= endt_nxt;
  end

endmodule

/* sv/ffa_checker.sv */
// Port-level checks for the first-fit allocator, bound to the top level.
// Depends on first_fit_allocator_with_wait_queue_defines.svh.
`include "first_fit_allocator_with_wait_queue_defines.svh"

module ffa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // Never take a transaction while a result is pending
  `FFA_ASSERT_NOW(a_busy_out, out_tvalid, !in_tready, "input ready with result pending")

  // Busy after taking a transaction
  `FFA_ASSERT_NEXT(a_busy_in, in_tvalid && in_tready, !in_tready, "ready after accept")

  // A dropped request is always a waiting one
  `FFA_ASSERT_NOW(a_ovf_wait, out_tvalid && out_tdata[64], out_tdata[0], "overflow without wait")

  // Hold a stalled result
  `FFA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
    "result changed while stalled")

endmodule

bind first_fit_allocator_with_wait_queue ffa_checker u_ffa_checker (.*);

/* tb/tb_first_fit_allocator_with_wait_queue.sv */
// Self-checking testbench for the timed first-fit allocator with its FIFO wait queue.
// Depends on ffa_pkg and first_fit_allocator_with_wait_queue; holds its own predictor.
`timescale 1ns / 100ps

module tb_first_fit_allocator_with_wait_queue;

  localparam int NBLK = 64;
  localparam int NWAIT = 64;
  localparam int unsigned NO_LINK = NBLK;
  localparam int unsigned WALK_GUARD = 2 * (NBLK + NWAIT) + 4;
  localparam int unsigned MAX31 = 32'h7FFF_FFFF;

  typedef struct packed {
    logic        waited;
    logic [30:0] count;
    logic [31:0] end_time;
    logic        ovf;
  } alloc_res_t;

  typedef struct {
    logic        op;
    logic [30:0] arr;
    logic [30:0] size;
    logic [30:0] hold;
    bit          typed;
    alloc_res_t  res;
  } alloc_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        cfg_we;
  logic [30:0] cfg_wdata;

  first_fit_allocator_with_wait_queue #(
    .MAX_BLOCKS (NBLK),
    .MAX_WAITING(NWAIT)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Allocator shadow state
  int unsigned mem_units;
  int unsigned blk_pos[NBLK], blk_len[NBLK], blk_rel[NBLK], blk_nxt[NBLK];
  bit          slot_open[NBLK];
  int unsigned blk_head;
  int unsigned wq_size[NWAIT], wq_hold[NWAIT];
  int unsigned wq_rd, wq_wr, wq_fill;
  int unsigned due_time;
  int unsigned waits_total;

  alloc_res_t  expected_res_q[$];
  bit          typed_q[$];
  alloc_res_t  typed_res_q[$];
  int          mismatches = 0;
  int          results_seen = 0, waits_seen = 0, drops_seen = 0, finishes_sent = 0;
  int          items_sent = 0;
  bit          long_stall_req = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("tb_first_fit_allocator_with_wait_queue: done, errors");
    $finish;
  end

  // First-fit placement; returns slot or NO_LINK
  function automatic int unsigned fit_block(int unsigned sz, int unsigned hd,
                                            int unsigned start);
    int unsigned slot = NO_LINK;
    int unsigned i, pos;
    longint unsigned lim, fin, rel;
    bit found = 0;
    for (int s = 0; s < NBLK; s++)
      if (slot_open[s] && slot == NO_LINK) slot = s;
    if (slot == NO_LINK) return NO_LINK;
    pos = 0;
    if (blk_head == NO_LINK || blk_pos[blk_head] >= sz) begin
      blk_nxt[slot] = blk_head;
      blk_head = slot;
    end else begin
      i = blk_head;
      while (i != NO_LINK && !found) begin
        lim = (blk_nxt[i] != NO_LINK) ? blk_pos[blk_nxt[i]] : mem_units;
        fin = longint'(blk_pos[i]) + blk_len[i];
        if (lim >= fin + sz) begin
          pos = 32'(fin);
          blk_nxt[slot] = blk_nxt[i];
          blk_nxt[i] = slot;
          found = 1;
        end else begin
          i = blk_nxt[i];
        end
      end
      if (!found) return NO_LINK;
    end
    rel = longint'(start) + hd;
    if (rel > ffa_pkg::LAST_TIME) rel = ffa_pkg::LAST_TIME;
    slot_open[slot] = 0;
    blk_pos[slot] = pos & MAX31;
    blk_len[slot] = sz;
    blk_rel[slot] = 32'(rel);
    return slot;
  endfunction

  // Free everything due at the earliest release, then place queue heads
  function automatic void release_due();
    int unsigned t = due_time;
    int unsigned soonest = ffa_pkg::NONE_PENDING;
    int unsigned prev = NO_LINK;
    int unsigned i = blk_head;
    int unsigned nx, slot;
    while (i != NO_LINK) begin
      nx = blk_nxt[i];
      if (blk_rel[i] == t) begin
        if (prev == NO_LINK) blk_head = nx;
        else blk_nxt[prev] = nx;
        slot_open[i] = 1;
      end else begin
        if (blk_rel[i] < soonest) soonest = blk_rel[i];
        prev = i;
      end
      i = nx;
    end
    while (wq_fill > 0) begin
      slot = fit_block(wq_size[wq_rd], wq_hold[wq_rd], t);
      if (slot == NO_LINK) break;
      if (blk_rel[slot] < soonest) soonest = blk_rel[slot];
      wq_rd = (wq_rd + 1) % NWAIT;
      wq_fill--;
    end
    due_time = soonest;
  endfunction

  // Advance the shadow allocator by one transaction
  function automatic alloc_res_t predict_alloc(logic op, int unsigned arr,
                                               int unsigned sz, int unsigned hd);
    alloc_res_t r = '0;
    int unsigned guard = 0;
    int unsigned slot, i;
    if (op == ffa_pkg::OP_FIN) begin
      while (wq_fill > 0 && guard < WALK_GUARD) begin
        release_due();
        guard++;
      end
      for (i = blk_head; i != NO_LINK; i = blk_nxt[i])
        if (blk_rel[i] > r.end_time) r.end_time = blk_rel[i];
    end else begin
      while (arr >= due_time && guard < WALK_GUARD) begin
        release_due();
        guard++;
      end
      slot = fit_block(sz, hd, arr);
      if (slot != NO_LINK) begin
        if (blk_rel[slot] < due_time) due_time = blk_rel[slot];
      end else begin
        r.waited = 1;
        if (waits_total < MAX31) waits_total++;
        if (wq_fill < NWAIT) begin
          wq_size[wq_wr] = sz;
          wq_hold[wq_wr] = hd;
          wq_wr = (wq_wr + 1) % NWAIT;
          wq_fill++;
        end else begin
          r.ovf = 1;
        end
      end
    end
    r.count = 31'(waits_total);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("%0t MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Predict on every accepted input transaction
  always @(posedge clk) begin
    alloc_res_t p;
    if (rst_n && in_tvalid && in_tready) begin
      p = predict_alloc(in_tuser, 32'(in_tdata[30:0]), 32'(in_tdata[61:31]),
                        32'(in_tdata[92:62]));
      if (typed_q.pop_front()) expected_res_q.push_back(typed_res_q.pop_front());
      else expected_res_q.push_back(p);
    end
  end

  // Check every accepted result transaction
  always @(posedge clk) begin
    alloc_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tdata[0]) waits_seen++;
      if (out_tdata[64]) drops_seen++;
      if (expected_res_q.size() == 0) begin
        report_mismatch("results outstanding", 1, 0);
      end else begin
        want = expected_res_q.pop_front();
        if (out_tdata[0] !== want.waited) report_mismatch("had_to_wait", out_tdata[0], want.waited);
        if (out_tdata[31:1] !== want.count) report_mismatch("wait_count", out_tdata[31:1], want.count);
        if (out_tdata[63:32] !== want.end_time)
          report_mismatch("end_time", out_tdata[63:32], want.end_time);
        if (out_tdata[64] !== want.ovf) report_mismatch("queue_overflow", out_tdata[64], want.ovf);
      end
    end
  end

  // Receiver: changing stall pattern, plus one long hold-off on request
  initial begin
    int mode = 0;
    int cyc = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        long_stall_req = 0;
      end else begin
        if (cyc % 64 == 0) mode = $urandom_range(0, 2);
        cyc++;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Sender burst bookkeeping
  int burst_left = 0;
  int unsigned clock_now = 0;

  task automatic send_row(alloc_row_t row);
    typed_q.push_back(row.typed);
    if (row.typed) typed_res_q.push_back(row.res);
    in_tvalid <= 1'b1;
    in_tuser  <= row.op;
    in_tdata  <= {3'b000, row.hold, row.size, row.arr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (row.op == ffa_pkg::OP_FIN) finishes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  // Drop valid, let every result come back, then settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_res_q.size() != 0 || typed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_mem_size(int unsigned units);
    cfg_we    <= 1'b1;
    cfg_wdata <= 31'(units);
    @(posedge clk);
    cfg_we    <= 1'b0;
    mem_units = units;
    @(posedge clk);
  endtask

  // Random traffic: mostly requests on a rising clock with small sizes and holds
  task automatic random_traffic(int n, int unsigned size_max, int unsigned hold_max,
                                int unsigned step_max, bit wide);
    alloc_row_t row;
    for (int k = 0; k < n; k++) begin
      row.typed = 0;
      row.op = ($urandom_range(0, 29) == 0) ? ffa_pkg::OP_FIN : ffa_pkg::OP_REQ;
      if ($urandom_range(0, 39) == 0) begin
        clock_now = (clock_now > 50) ? clock_now - $urandom_range(1, 50) : 0;
      end else if (wide && $urandom_range(0, 7) == 0) begin
        clock_now = $urandom_range(clock_now, MAX31);
      end else begin
        clock_now = clock_now + $urandom_range(0, step_max);
        if (clock_now > MAX31) clock_now = MAX31;
      end
      row.arr  = 31'(clock_now);
      row.size = ($urandom_range(0, 39) == 0) ? 31'($urandom_range(1, MAX31))
                                              : 31'($urandom_range(1, size_max));
      row.hold = (wide && $urandom_range(0, 5) == 0) ? 31'($urandom_range(1, MAX31))
                                                     : 31'($urandom_range(1, hold_max));
      if (!wide && $urandom_range(0, 59) == 0) row.hold = 31'($urandom_range(1, MAX31));
      send_row(row);
      if (k == 100 && size_max == 200) long_stall_req = 1;
    end
  endtask

  alloc_row_t directed_rows[] = '{
    '{ffa_pkg::OP_REQ, 31'd0,  31'd1024,  31'd10, 1'b1, '{1'b0, 31'd0, 32'd0,  1'b0}},
    '{ffa_pkg::OP_REQ, 31'd0,  31'd1,     31'd5,  1'b1, '{1'b1, 31'd1, 32'd0,  1'b0}},
    '{ffa_pkg::OP_FIN, 31'd0,  31'd1,     31'd1,  1'b1, '{1'b0, 31'd1, 32'd15, 1'b0}},
    '{ffa_pkg::OP_REQ, 31'd20, MAX31[30:0], 31'd1, 1'b1, '{1'b0, 31'd1, 32'd0, 1'b0}},
    '{ffa_pkg::OP_REQ, 31'd21, 31'd1,     31'd100, 1'b0, '{1'b0, 31'd0, 32'd0, 1'b0}},
    '{ffa_pkg::OP_REQ, 31'd22, 31'd1024,  31'd3,  1'b0, '{1'b0, 31'd0, 32'd0,  1'b0}},
    '{ffa_pkg::OP_REQ, 31'd10, 31'd4,     31'd3,  1'b0, '{1'b0, 31'd0, 32'd0,  1'b0}},
    '{ffa_pkg::OP_REQ, 31'd121, 31'd512,  31'd7,  1'b0, '{1'b0, 31'd0, 32'd0,  1'b0}},
    '{ffa_pkg::OP_REQ, 31'd121, 31'd512,  31'd7,  1'b0, '{1'b0, 31'd0, 32'd0,  1'b0}},
    '{ffa_pkg::OP_REQ, 31'd121, 31'd1,    31'd7,  1'b0, '{1'b0, 31'd0, 32'd0,  1'b0}},
    '{ffa_pkg::OP_FIN, 31'd121, 31'd1,    31'd1,  1'b0, '{1'b0, 31'd0, 32'd0,  1'b0}},
    '{ffa_pkg::OP_REQ, 31'd500, 31'd10,   31'd1,  1'b0, '{1'b0, 31'd0, 32'd0,  1'b0}},
    '{ffa_pkg::OP_FIN, 31'd501, 31'd1,    31'd1,  1'b0, '{1'b0, 31'd0, 32'd0,  1'b0}}
  };

  initial begin
    alloc_row_t row;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = ffa_pkg::OP_REQ;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    mem_units = 1024;
    for (int s = 0; s < NBLK; s++) begin
      slot_open[s] = 1;
      blk_nxt[s] = NO_LINK;
    end
    blk_head = NO_LINK;
    wq_rd = 0; wq_wr = 0; wq_fill = 0;
    due_time = ffa_pkg::NONE_PENDING;
    waits_total = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at the reset memory size
    foreach (directed_rows[k]) send_row(directed_rows[k]);
    clock_now = 501;
    random_traffic(240, 200, 60, 4, 0);
    drain();

    // One unit of memory: nearly everything waits, queue overflows
    write_mem_size(1);
    random_traffic(150, 1, 400, 2, 0);
    drain();

    // Largest memory: table fills up before space runs out
    write_mem_size(MAX31);
    random_traffic(200, 100000, 500, 3, 0);
    drain();

    write_mem_size(300);
    random_traffic(250, 60, 40, 3, 0);
    drain();

    write_mem_size($urandom_range(1, 4096));
    random_traffic(140, 300, 80, 5, 0);
    drain();

    // Late times: wide arrivals and holds, release time saturation
    write_mem_size(MAX31);
    random_traffic(60, MAX31, 100, 1000, 1);
    row = '{ffa_pkg::OP_REQ, MAX31[30:0], 31'd1, MAX31[30:0], 1'b0, '0};
    send_row(row);
    row.op = ffa_pkg::OP_FIN;
    send_row(row);
    drain();

    $display("sent %0d transactions (%0d finish) across six memory sizes", items_sent,
             finishes_sent);
    $display("checked %0d results: %0d waited, %0d dropped on a full queue", results_seen,
             waits_seen, drops_seen);
    if (mismatches == 0) begin
      $display("tb_first_fit_allocator_with_wait_queue: done, clean");
    end else begin
      $display("tb_first_fit_allocator_with_wait_queue: done, errors");
    end
    $finish;
  end

endmodule
